@@ sv/mfb_pkg.sv @@
`default_nettype none

package mfb_pkg;

	// default frame geometry
	localparam int FRAME_COLUMNS = 128;
	localparam int FRAME_PAGES   = 8;

	// operation codes
	localparam logic [1:0] FUNC_PIXEL = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_PAGE  = 2'd2;

	// one request
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] pixel_column;
		logic [7:0] pixel_row;
		logic       pixel_on;
		logic [3:0] page_select;
	} mfb_cmd_t;

	// one readout byte
	typedef struct packed {
		logic [7:0] page_byte;
		logic [3:0] page_index;
		logic [5:0] byte_offset;
		logic       last_byte;
	} mfb_result_t;

	// store read data landing in the transpose buffer
	typedef struct packed {
		logic       wr;
		logic       bank;
		logic [2:0] slot;
	} mfb_fill_t;

	// transpose byte selection
	typedef struct packed {
		logic       en;
		logic       bank;
		logic [2:0] row;
		logic       mirror;
	} mfb_emit_t;

endpackage

`default_nettype wire

@@ sv/mfb_ram.sv @@
`default_nettype none

module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

@@ sv/mfb_transpose.sv @@
`default_nettype none

module mfb_transpose (
	input  wire logic               clk,
	input  wire mfb_pkg::mfb_fill_t fill,
	input  wire logic [7:0]         rd_data,
	input  wire mfb_pkg::mfb_emit_t emit,
	output logic      [7:0]         page_byte
);

	logic [7:0] bank0_q [8];
	logic [7:0] bank1_q [8];
	logic [7:0] sel_w   [8];
	logic [7:0] byte_w;
	logic [7:0] byte_q;

	// ping-pong column buffers, one group of 8 columns each
	always_ff @(posedge clk) begin
		if (fill.wr) begin
			if (fill.bank) begin
				bank1_q[fill.slot] <= rd_data;
			end else begin
				bank0_q[fill.slot] <= rd_data;
			end
		end
	end

	// 8x8 bit transpose of the selected bank
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			sel_w[j] = emit.bank ? bank1_q[j] : bank0_q[j];
		end
		byte_w = '0;
		for (int j = 0; j < 8; j++) begin
			if (emit.mirror) begin
				byte_w[j] = sel_w[j][~emit.row];
			end else begin
				byte_w[7-j] = sel_w[j][emit.row];
			end
		end
	end

	// output byte register
	always_ff @(posedge clk) begin
		if (emit.en) begin
			byte_q <= byte_w;
		end
	end

	assign page_byte = byte_q;

endmodule

`default_nettype wire

@@ sv/mono_framebuffer_rotated_readout_top.sv @@
// page readout: busy while the readout runs; the first byte follows the first full column group,
//   then one byte per cycle from one store read per byte, two column groups in flight
// pixel write: one read-modify-write of the store
// clear request and reset: a zeroing sweep of all FRAME_COLUMNS*FRAME_PAGES store bytes (1024) with busy high
// results come with a one-cycle strobe and cannot be stalled
// asynchronous active-low reset clears control state and mirror mode, then sweeps the store
`default_nettype none

module mono_framebuffer_rotated_readout_top #(
	parameter int FRAME_COLUMNS = mfb_pkg::FRAME_COLUMNS,
	parameter int FRAME_PAGES   = mfb_pkg::FRAME_PAGES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire mfb_pkg::mfb_cmd_t    cmd,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	output logic                      result_valid,
	output mfb_pkg::mfb_result_t      result
);

	localparam int STORE_SIZE = FRAME_COLUMNS * FRAME_PAGES;
	localparam int DISP_PAGES = FRAME_COLUMNS / 8;
	localparam int PAGE_BYTES = FRAME_PAGES * 8;
	localparam int AW         = $clog2(STORE_SIZE);
	localparam int CW         = $clog2(PAGE_BYTES + 9);
	localparam int CLW        = ($clog2(FRAME_COLUMNS) > 4) ? $clog2(FRAME_COLUMNS) : 4;
	localparam int EMIT_START = 9;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_PIX_WR = 3'd2;
	localparam logic [2:0] ST_PAGE   = 3'd3;

	logic [2:0]     state_q;
	logic [AW-1:0]  clr_q;
	logic [CW-1:0]  cnt_q;
	logic [3:0]     page_q;
	logic           mirror_q;
	logic [AW-1:0]  pix_addr_q;
	logic [7:0]     pix_mask_q;
	logic           pix_on_q;

	logic           accept_w;
	logic           pix_ok_w;
	logic           page_ok_w;
	logic [AW-1:0]  pix_addr_w;
	logic [CW-4:0]  grp_w;
	logic [CLW-4:0] base_w;
	logic [CLW-1:0] col_w;
	logic [31:0]    spage_w;
	logic [AW-1:0]  rd_addr_w;
	logic           rd_en_w;
	logic [CW-1:0]  emit_idx_w;

	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [7:0]     ram_wdata;
	logic [7:0]     ram_rdata;

	mfb_pkg::mfb_fill_t fill_s1;
	mfb_pkg::mfb_emit_t emit_w;

	logic           valid_q;
	logic [3:0]     res_page_q;
	logic [5:0]     res_off_q;
	logic           res_last_q;
	logic [7:0]     page_byte_w;

	assign busy     = (state_q != ST_IDLE);
	assign accept_w = start && !busy;

	// request decode
	assign pix_ok_w   = (32'(cmd.pixel_column) < FRAME_COLUMNS) &&
	                    (32'(cmd.pixel_row) < PAGE_BYTES);
	assign page_ok_w  = (32'(cmd.page_select) < DISP_PAGES);
	assign pix_addr_w = AW'(32'(cmd.pixel_row[7:3]) * FRAME_COLUMNS + 32'(cmd.pixel_column));

	// readout address: group of 8 columns, column within group from the low count bits
	assign grp_w     = cnt_q[CW-1:3];
	assign base_w    = mirror_q ? (CLW-3)'(page_q) : (CLW-3)'(DISP_PAGES - 1) - (CLW-3)'(page_q);
	assign col_w     = {base_w, cnt_q[2:0]};
	assign spage_w   = mirror_q ? 32'(FRAME_PAGES - 1) - 32'(grp_w) : 32'(grp_w);
	assign rd_addr_w = AW'(spage_w * FRAME_COLUMNS + 32'(col_w));
	assign rd_en_w   = (state_q == ST_PAGE) && (32'(cnt_q) < PAGE_BYTES);

	// emission trails the reads by one full group plus the read latency
	assign emit_idx_w   = cnt_q - CW'(EMIT_START);
	assign emit_w.en     = (state_q == ST_PAGE) && (32'(cnt_q) >= EMIT_START);
	assign emit_w.bank   = emit_idx_w[3];
	assign emit_w.row    = emit_idx_w[2:0];
	assign emit_w.mirror = mirror_q;

	// store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pix_addr_w;
		ram_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_PIX_WR: begin
				ram_we    = 1'b1;
				ram_addr  = pix_addr_q;
				ram_wdata = pix_on_q ? (ram_rdata | pix_mask_q) : (ram_rdata & ~pix_mask_q);
			end
			ST_PAGE: begin
				ram_addr = rd_addr_w;
			end
			default: begin
				ram_addr = pix_addr_w;
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == STORE_SIZE - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (cmd.func)
							mfb_pkg::FUNC_PIXEL: begin
								if (pix_ok_w) begin
									state_q <= ST_PIX_WR;
								end
							end
							mfb_pkg::FUNC_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							mfb_pkg::FUNC_PAGE: begin
								if (page_ok_w) begin
									cnt_q   <= '0;
									state_q <= ST_PAGE;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PIX_WR: begin
					state_q <= ST_IDLE;
				end
				ST_PAGE: begin
					cnt_q <= cnt_q + CW'(1);
					if (32'(cnt_q) == PAGE_BYTES + EMIT_START - 1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (accept_w) begin
			pix_addr_q <= pix_addr_w;
			pix_mask_q <= 8'(1) << cmd.pixel_row[2:0];
			pix_on_q   <= cmd.pixel_on;
			page_q     <= cmd.page_select;
		end
	end

	// mirror mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
		end else if (cfg_we) begin
			mirror_q <= cfg_wdata;
		end
	end

	// read data tag, aligned with the store output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_s1 <= '0;
		end else begin
			fill_s1.wr   <= rd_en_w;
			fill_s1.bank <= cnt_q[3];
			fill_s1.slot <= cnt_q[2:0];
		end
	end

	// result strobe and tag fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= emit_w.en;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_w.en) begin
			res_page_q <= page_q;
			res_off_q  <= 6'(emit_idx_w);
			res_last_q <= (32'(emit_idx_w) == PAGE_BYTES - 1);
		end
	end

	mfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_SIZE)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	mfb_transpose u_transpose (
		.clk      (clk),
		.fill     (fill_s1),
		.rd_data  (ram_rdata),
		.emit     (emit_w),
		.page_byte(page_byte_w)
	);

	assign result_valid       = valid_q;
	assign result.page_byte   = page_byte_w;
	assign result.page_index  = res_page_q;
	assign result.byte_offset = res_off_q;
	assign result.last_byte   = res_last_q;

	// a result byte only follows a readout cycle
	a_result_from_page: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_PAGE))
		else $error("result without readout");

	// the store is never written during a readout
	a_no_write_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && state_q == ST_PAGE))
		else $error("store write during readout");

	// a valid page request starts a readout
	a_page_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_w && cmd.func == mfb_pkg::FUNC_PAGE && page_ok_w) |=> (state_q == ST_PAGE))
		else $error("page request not started");

	// the last byte closes the readout
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_byte) |-> (state_q == ST_IDLE))
		else $error("last byte while still reading");

	// read data tags only appear in the cycle after a readout read
	a_fill_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		fill_s1.wr |-> $past(rd_en_w))
		else $error("buffer fill without store read");

endmodule

`default_nettype wire
